@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");
// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/tle_pkg.sv @@
// ----------------------------------------------------------------------------
// tle_pkg
// Types and constants shared by the line editor front, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

	// Default line store depth
	localparam int LINE_DEPTH_DEF = 32;

	// Command queue depth and pointer width
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Key codes
	localparam logic [7:0] KEY_BACKSPACE = 8'h08;
	localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
	localparam logic [7:0] KEY_INTERRUPT = 8'h03;
	localparam logic [7:0] KEY_SPACE     = 8'h20;

	// Output channel codes
	localparam logic CH_ECHO = 1'b0;
	localparam logic CH_LINE = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ENABLE    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANONICAL_MODE = 1'd1;

	// Classified keyboard byte
	typedef struct packed {
		logic [7:0] key;
		logic       echo;
		logic       erase;
		logic       flush;
	} tle_cmd_t;

	// Queue status
	typedef struct packed {
		logic full;
		logic empty;
	} tle_qstat_t;

	// Back end status
	typedef struct packed {
		logic busy;
	} tle_bstat_t;

	// Back end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BS1,
		ST_SP,
		ST_BS2,
		ST_CHAR,
		ST_FLUSH
	} tle_state_t;

endpackage

`default_nettype wire

@@ rtl/tty_canonical_line_editor.sv @@
// ----------------------------------------------------------------------------
// tty_canonical_line_editor
// Terminal line discipline: echo, backspace editing and line flush.
// ----------------------------------------------------------------------------
// Usage:
//   Keyboard bytes enter on the s_ stream, one byte per transaction.
//   Results leave on the m_ stream: m_tdata is the byte, m_tuser selects the
//   channel (0 display echo, 1 line data for the reader), m_tlast marks the
//   final result caused by one keyboard byte. A byte may cause no result.
//   The cfg_ channel writes echo_enable (index 0) and canonical_mode
//   (index 1); write them only while the block is idle.
//   A taken byte passes the command queue, the sequencer state and the
//   output register before its first result appears. Throughput: a byte
//   starts while the back end is idle, then results leave one per cycle while
//   m_tready allows (echo of one or three bytes, then the flushed line bytes).
//   The single output register and the line store read port set this pace.
//   A two-entry command queue lets a new byte be taken while results drain.
//   Reset clears the line count and sets both modes on; store contents need
//   no clearing. A stall on m_tready holds the result and pauses the back
//   end; s_tready drops once the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tty_canonical_line_editor
	import tle_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic                 cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,   // [7:0] key_byte
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata,   // [7:0] out_byte
	output logic                      m_tuser,   // [0] out_channel
	output logic                      m_tlast
);

	tle_qstat_t qstat;
	tle_bstat_t bstat;
	tle_cmd_t   push_cmd;
	tle_cmd_t   pop_cmd;
	logic       push;
	logic       pop;
	logic       pop_valid;

	tle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.qstat     (qstat),
		.push      (push),
		.cmd       (push_cmd)
	);

	tle_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_cmd   (push_cmd),
		.pop      (pop),
		.rd_valid (pop_valid),
		.rd_cmd   (pop_cmd),
		.qstat    (qstat)
	);

	tle_back #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.cmd_pop   (pop),
		.bstat     (bstat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// An accepted byte leaves the queue non-empty
	`ASSERT_NEXT(a_push_fills, clk, arst_n, push, !qstat.empty)
	// A result only appears while the back end is working
	`ASSERT_IMPLIES(a_out_from_busy, clk, arst_n, $rose(m_tvalid), $past(bstat.busy))
	// Queue is never full and empty together
	`ASSERT_IMPLIES(a_q_sane, clk, arst_n, qstat.full, !qstat.empty)
	// The back end never pops an empty queue
	`ASSERT_IMPLIES(a_pop_valid, clk, arst_n, pop, !qstat.empty)

endmodule

`default_nettype wire

@@ rtl/tle_front.sv @@
// ----------------------------------------------------------------------------
// tle_front
// Holds the mode registers, accepts keyboard bytes and classifies each one
// into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_front
	import tle_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic                 cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,
	input  wire tle_qstat_t           qstat,
	output logic                      push,
	output tle_cmd_t                  cmd
);

	logic echo_q;
	logic canon_q;

	// Mode registers, written any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_q  <= 1'b1;
			canon_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ECHO_ENABLE:    echo_q  <= cfg_data;
				CFG_CANONICAL_MODE: canon_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Accept while the queue has room
	assign s_tready = !qstat.full;
	assign push     = s_tvalid && s_tready;

	// Classify the byte against the current modes
	always_comb begin
		cmd.key   = s_tdata;
		cmd.echo  = echo_q;
		cmd.erase = canon_q && (s_tdata == KEY_BACKSPACE);
		cmd.flush = (s_tdata == KEY_NEWLINE) || (s_tdata == KEY_INTERRUPT) || !canon_q;
	end

endmodule

`default_nettype wire

@@ rtl/tle_fifo.sv @@
// ----------------------------------------------------------------------------
// tle_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_fifo
	import tle_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire tle_cmd_t wr_cmd,
	input  wire logic     pop,
	output logic          rd_valid,
	output tle_cmd_t      rd_cmd,
	output tle_qstat_t    qstat
);

	tle_cmd_t            ent_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	// Status
	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign rd_valid    = !qstat.empty;
	assign rd_cmd      = ent_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/tle_back.sv @@
// ----------------------------------------------------------------------------
// tle_back
// Executes commands: updates the line store, emits echo bytes and flushes
// the stored line through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_back
	import tle_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	input  wire tle_cmd_t cmd,
	output logic          cmd_pop,
	output tle_bstat_t    bstat,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	output logic [7:0]    m_tdata,
	output logic          m_tuser,
	output logic          m_tlast
);

	localparam int CW = $clog2(LINE_DEPTH + 1);
	localparam int AW = $clog2(LINE_DEPTH);

	tle_state_t state_q, state_d;

	logic [7:0]    mem_q [LINE_DEPTH];
	logic [7:0]    rdata_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] flush_n_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx_d;
	logic [7:0]    key_q;

	logic          slot_free;
	logic          append;
	logic          wr_en;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [CW-1:0] new_count;
	logic [CW-1:0] count_d;
	logic [CW-1:0] flush_n_d;
	logic          erase_echo;
	logic          plain_echo;

	logic          emit;
	logic [7:0]    emit_byte;
	logic          emit_chan;
	logic          emit_last;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_chan_q;
	logic          out_last_q;

	assign slot_free  = !out_valid_q || m_tready;
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid;
	assign bstat.busy = (state_q != ST_IDLE);

	// Decode the popped command against the line count
	always_comb begin
		append     = !cmd.erase && (count_q < CW'(LINE_DEPTH));
		erase_echo = cmd.echo && cmd.erase && (count_q != '0);
		plain_echo = cmd.echo && !cmd.erase;
		if (cmd.erase) begin
			new_count = (count_q != '0) ? count_q - CW'(1) : count_q;
		end else if (append) begin
			new_count = count_q + CW'(1);
		end else begin
			new_count = count_q;
		end
		flush_n_d = cmd.flush ? new_count : '0;
		count_d   = cmd.flush ? '0 : new_count;
	end

	assign wr_en = cmd_pop && append;
	assign waddr = count_q[AW-1:0];

	// Next read index keeps rdata_q aligned with idx_q
	always_comb begin
		if (state_q == ST_FLUSH && slot_free) begin
			idx_d = idx_q + CW'(1);
		end else if (cmd_pop) begin
			idx_d = '0;
		end else begin
			idx_d = idx_q;
		end
		raddr = (idx_d < CW'(LINE_DEPTH)) ? idx_d[AW-1:0] : '0;
	end

	// Line store with registered read and write bypass
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[waddr] <= cmd.key;
		end
		if (wr_en && (waddr == raddr)) begin
			rdata_q <= cmd.key;
		end else begin
			rdata_q <= mem_q[raddr];
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (erase_echo) begin
						state_d = ST_BS1;
					end else if (plain_echo) begin
						state_d = ST_CHAR;
					end else if (flush_n_d != '0) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_BS1:  if (slot_free) state_d = ST_SP;
			ST_SP:   if (slot_free) state_d = ST_BS2;
			ST_BS2: begin
				if (slot_free) begin
					state_d = (flush_n_q != '0) ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_CHAR: begin
				if (slot_free) begin
					state_d = (flush_n_q != '0) ? ST_FLUSH : ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (slot_free && ((idx_q + CW'(1)) == flush_n_q)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Result selection per state
	always_comb begin
		emit      = 1'b0;
		emit_byte = key_q;
		emit_chan = CH_ECHO;
		emit_last = 1'b0;
		case (state_q)
			ST_BS1: begin
				emit      = slot_free;
				emit_byte = KEY_BACKSPACE;
			end
			ST_SP: begin
				emit      = slot_free;
				emit_byte = KEY_SPACE;
			end
			ST_BS2: begin
				emit      = slot_free;
				emit_byte = KEY_BACKSPACE;
				emit_last = (flush_n_q == '0);
			end
			ST_CHAR: begin
				emit      = slot_free;
				emit_byte = key_q;
				emit_last = (flush_n_q == '0);
			end
			ST_FLUSH: begin
				emit      = slot_free;
				emit_byte = rdata_q;
				emit_chan = CH_LINE;
				emit_last = ((idx_q + CW'(1)) == flush_n_q);
			end
			default: ;
		endcase
	end

	// Sequencer and line count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			flush_n_q <= '0;
			idx_q     <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (cmd_pop) begin
				count_q   <= count_d;
				flush_n_q <= flush_n_d;
			end
		end
	end

	// Hold the typed byte for its echo
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			key_q <= cmd.key;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_chan_q <= emit_chan;
			out_last_q <= emit_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = out_chan_q;
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire
